// File: rtl/mps_pkg.sv
package mps_pkg;

  localparam int PAT_BYTES      = 16;
  localparam int PAT_LEN_W      = 5;
  localparam int BYTE_W         = 8;
  localparam int CFG_IDX_W      = 8;
  localparam int CFG_DATA_W     = 64;
  localparam int OFFSET_FIELD_W = 32;

  localparam logic [PAT_BYTES-1:0] CARE_RESET = '1;
  localparam logic [PAT_LEN_W-1:0] LEN_RESET  = 5'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LO = 8'd0,
    CFG_PAT_HI = 8'd1,
    CFG_CARE   = 8'd2,
    CFG_LEN    = 8'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] pat_lo;
    logic [CFG_DATA_W-1:0] pat_hi;
    logic [PAT_BYTES-1:0]  care;
    logic [PAT_LEN_W-1:0]  plen;
  } cfg_t;

  typedef struct packed {
    logic                 hit;
    logic [PAT_LEN_W-1:0] len;
  } cmp_t;

endpackage

// File: rtl/masked_pattern_scan_unit.sv
// Channel  Direction  Handshake          Word
// in_      input      in_valid/in_stall  in_region_byte, in_region_last
// out_     output     out_valid/out_stall out_found, out_match_offset
// cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_wdata
//
// One byte per cycle while out_stall does not hold the result register; a word's result goes
// through the input register, then the window compare, into the result register.
// Reset is synchronous, active low; it clears the window and counter and loads the
// reset pattern setup (pattern zero, all care bits set, length one).
// out_stall holds the result register while out_valid is high and backs up into in_stall in the same cycle.
// cfg_ready is always high; writes land at once.
module masked_pattern_scan_unit #(
  parameter int MAX_PATTERN = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [mps_pkg::BYTE_W-1:0]              in_region_byte,
  input  logic                                    in_region_last,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic                                    out_found,
  output logic [mps_pkg::OFFSET_FIELD_W-1:0]      out_match_offset,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [mps_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [mps_pkg::CFG_DATA_W-1:0]          cfg_wdata
);

  localparam int ExtW = (OFFSET_BITS > mps_pkg::OFFSET_FIELD_W) ?
                        OFFSET_BITS : mps_pkg::OFFSET_FIELD_W;

  mps_pkg::cfg_t cfg;
  mps_pkg::cmp_t cmp;

  logic                              in_valid_r;
  logic [mps_pkg::BYTE_W-1:0]        in_byte_r;
  logic                              in_last_r;

  logic [OFFSET_BITS-1:0]            bytes_seen_r;
  logic [OFFSET_BITS-1:0]            cnt_nxt;
  logic [OFFSET_BITS-1:0]            len_ext;
  logic [OFFSET_BITS-1:0]            diff;
  logic [ExtW-1:0]                   diff_ext;
  logic                              counted;
  logic                              match_reported_r;

  logic                              out_valid_r;
  logic                              out_found_r;
  logic [mps_pkg::OFFSET_FIELD_W-1:0] out_offset_r;

  logic                              out_free;
  logic                              adv;
  logic                              hit;
  logic                              emit;

  mps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mps_window #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (adv),
    .new_byte (in_byte_r),
    .cfg      (cfg),
    .cmp      (cmp)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign adv      = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  assign counted  = ~&bytes_seen_r;
  assign cnt_nxt  = counted ? bytes_seen_r + OFFSET_BITS'(1) : bytes_seen_r;
  assign len_ext  = OFFSET_BITS'(cmp.len);
  assign diff     = cnt_nxt - len_ext;
  assign diff_ext = ExtW'(diff);

  assign hit  = !match_reported_r && counted && cmp.hit && (cnt_nxt >= len_ext);
  assign emit = hit || (in_last_r && !match_reported_r);

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_match_offset = out_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_region_byte;
      in_last_r <= in_region_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r     <= '0;
      match_reported_r <= 1'b0;
    end else if (adv) begin
      if (in_last_r) begin
        bytes_seen_r     <= '0;
        match_reported_r <= 1'b0;
      end else begin
        bytes_seen_r <= cnt_nxt;
        if (hit) begin
          match_reported_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= adv && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && adv) begin
      out_found_r  <= hit;
      out_offset_r <= hit ? diff_ext[mps_pkg::OFFSET_FIELD_W-1:0] : '0;
    end
  end

`ifndef SYNTHESIS
  a_nf_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_offset_r == '0)
    else $error("not-found word with nonzero offset");

  a_single_found: assert property (@(posedge clk) disable iff (!rst_n)
    adv && match_reported_r |=> !(out_valid_r && out_found_r))
    else $error("second found word in one region");

  a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_last_r |=> bytes_seen_r == '0 && !match_reported_r)
    else $error("region state not cleared after last byte");

  a_cnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !in_last_r |=> bytes_seen_r >= $past(bytes_seen_r))
    else $error("byte counter went backwards");

  a_stall_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r && out_valid_r)
    else $error("input stalled with nothing blocking");
`endif

endmodule

// File: rtl/mps_cfg.sv
module mps_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mps_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output mps_pkg::cfg_t                       cfg
);

  mps_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pat_lo <= '0;
      cfg_r.pat_hi <= '0;
      cfg_r.care   <= mps_pkg::CARE_RESET;
      cfg_r.plen   <= mps_pkg::LEN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        mps_pkg::CFG_PAT_LO: cfg_r.pat_lo <= cfg_wdata;
        mps_pkg::CFG_PAT_HI: cfg_r.pat_hi <= cfg_wdata;
        mps_pkg::CFG_CARE:   cfg_r.care   <= cfg_wdata[mps_pkg::PAT_BYTES-1:0];
        mps_pkg::CFG_LEN:    cfg_r.plen   <= cfg_wdata[mps_pkg::PAT_LEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/mps_window.sv
module mps_window #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          shift_en,
  input  logic [mps_pkg::BYTE_W-1:0]    new_byte,
  input  mps_pkg::cfg_t                 cfg,
  output mps_pkg::cmp_t                 cmp
);

  localparam int IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [mps_pkg::BYTE_W-1:0]      win_r   [MAX_PATTERN];
  logic [mps_pkg::BYTE_W-1:0]      win_nxt [MAX_PATTERN];
  logic [2*mps_pkg::CFG_DATA_W-1:0] pat_all;
  logic [mps_pkg::PAT_LEN_W-1:0]   len;
  logic [MAX_PATTERN-1:0]          miss;

  assign pat_all = {cfg.pat_hi, cfg.pat_lo};
  assign len     = (cfg.plen > mps_pkg::PAT_LEN_W'(MAX_PATTERN)) ?
                   mps_pkg::PAT_LEN_W'(MAX_PATTERN) : cfg.plen;

  assign win_nxt[0] = new_byte;
  for (genvar k = 1; k < MAX_PATTERN; k++) begin : g_shift
    assign win_nxt[k] = win_r[k-1];
  end

  // pattern byte i lines up with the byte received len-1-i items ago
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cmp
    logic [mps_pkg::PAT_LEN_W-1:0] j;
    logic                          active;
    assign j      = len - mps_pkg::PAT_LEN_W'(1) - mps_pkg::PAT_LEN_W'(i);
    assign active = (mps_pkg::PAT_LEN_W'(i) < len) && cfg.care[i];
    assign miss[i] = active &&
                     (win_nxt[j[IdxW-1:0]] != pat_all[i*mps_pkg::BYTE_W +: mps_pkg::BYTE_W]);
  end

  assign cmp.hit = (len != '0) && !(|miss);
  assign cmp.len = len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_r[k] <= '0;
      end
    end else if (shift_en) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
  end

endmodule
